FILE: sv/rational_arithmetic_unit_defines.svh
// ---------------------------------------------------------------------------
// rational arithmetic unit assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg
// operation, status and iterative unit command codes
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NORM = 3'd4;
    localparam logic [2:0] OP_NEG = 3'd5;
    localparam logic [2:0] OP_EQ = 3'd6;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_ZDEN = 2'd2;

    localparam logic [1:0] CMD_MUL = 2'd0;
    localparam logic [1:0] CMD_DIV = 2'd1;
    localparam logic [1:0] CMD_GCD = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] cmd;
    } t_iter_req;

endpackage

FILE: sv/rau_iter.sv
// ---------------------------------------------------------------------------
// rau_iter
// shared iterative unit: shift-add multiply, restoring divide, binary gcd,
// all built around one subtract/add of WORD_BITS+1 bits
// ---------------------------------------------------------------------------
module rau_iter
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_iter_req                i_req,
    input  logic [WORD_BITS-1:0]     i_x,
    input  logic [WORD_BITS-1:0]     i_y,
    output logic                     o_done,
    output logic [2*WORD_BITS-1:0]   o_prod,
    output logic [WORD_BITS-1:0]     o_res
);

    localparam int W = WORD_BITS;
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic          r_fix;
    logic [1:0]    r_cmd;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_k;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;
    logic [W:0]    r_hi;

    logic [W:0]    add_a;
    logic [W:0]    add_b;
    logic          add_sub;
    logic [W+1:0]  add_s;
    logic          carry;

    always_comb begin
        unique case (r_cmd)
            CMD_MUL: begin
                add_a   = r_hi;
                add_b   = {1'b0, r_y};
                add_sub = 1'b0;
            end
            CMD_DIV: begin
                add_a   = {r_hi[W-1:0], r_x[W-1]};
                add_b   = {1'b0, r_y};
                add_sub = 1'b1;
            end
            default: begin
                add_a   = {1'b0, r_x};
                add_b   = {1'b0, r_y};
                add_sub = 1'b1;
            end
        endcase
        add_s = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (W+2)'(add_sub);
        carry = add_s[W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_fix  <= 1'b0;
            r_cmd  <= CMD_MUL;
            r_cnt  <= '0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cmd  <= i_req.cmd;
                r_x    <= i_x;
                r_y    <= i_y;
                r_hi   <= '0;
                r_cnt  <= CW'(W);
                r_k    <= '0;
                r_fix  <= 1'b0;
            end else if (r_busy) begin
                unique case (r_cmd)
                    CMD_MUL: begin
                        if (r_x[0]) begin
                            r_hi <= {1'b0, add_s[W:1]};
                            r_x  <= {add_s[0], r_x[W-1:1]};
                        end else begin
                            r_hi <= {1'b0, r_hi[W:1]};
                            r_x  <= {r_hi[0], r_x[W-1:1]};
                        end
                        r_cnt <= r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    CMD_DIV: begin
                        // restoring step: quotient bit shifts in at the bottom
                        if (carry) begin
                            r_hi <= {1'b0, add_s[W-1:0]};
                        end else begin
                            r_hi <= {1'b0, add_a[W-1:0]};
                        end
                        r_x   <= {r_x[W-2:0], carry};
                        r_cnt <= r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    CMD_GCD: begin
                        if (r_fix) begin
                            // restore the common power of two
                            if (r_k == '0) begin
                                r_busy <= 1'b0;
                                r_done <= 1'b1;
                            end else begin
                                r_x <= {r_x[W-2:0], 1'b0};
                                r_k <= r_k - CW'(1);
                            end
                        end else if (!r_x[0] && !r_y[0]) begin
                            r_x <= {1'b0, r_x[W-1:1]};
                            r_y <= {1'b0, r_y[W-1:1]};
                            r_k <= r_k + CW'(1);
                        end else if (!r_x[0]) begin
                            r_x <= {1'b0, r_x[W-1:1]};
                        end else if (!r_y[0]) begin
                            r_y <= {1'b0, r_y[W-1:1]};
                        end else if (add_s[W:0] == '0) begin
                            r_fix <= 1'b1;
                        end else if (!carry) begin
                            r_x <= r_y;
                            r_y <= r_x;
                        end else begin
                            r_x <= add_s[W-1:0];
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[W-1:0], r_x};
    assign o_res  = r_x;

endmodule

FILE: sv/rational_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// rational_arithmetic_unit
// exact add, sub, mul, div, normalize, negate and compare on signed fractions
// with gcd reduction; results are sign/magnitude internally
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_operation, i_a_num, i_a_den,
//                                            i_b_num, i_b_den
//  result    out        o_valid / i_stall    o_result_num, o_result_den,
//                                            o_status, o_is_equal,
//                                            o_is_zero, o_is_one
//
// one transaction at a time; negate, equal and early zero/overflow cases go
// straight to the done state, add/sub use three products (M1, M2, M3) and
// multiply/divide two (M1, M3), then the gcd and the two quotient divisions
// follow, all on the single shared iterative unit
// o_stall is high from acceptance until the result moves to the output
// register; a stalled result holds while the next transaction is accepted
// synchronous active-low reset clears the sequencer and the output valid
// ---------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic [63:0] i_a_num,
    input  logic [63:0] i_a_den,
    input  logic [63:0] i_b_num,
    input  logic [63:0] i_b_den,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_num,
    output logic [63:0] o_result_den,
    output logic [1:0]  o_status,
    output logic        o_is_equal,
    output logic        o_is_zero,
    output logic        o_is_one
);

    localparam int W = WORD_BITS;
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;
    localparam logic [3:0] S_M2   = 4'd2;
    localparam logic [3:0] S_ADD  = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_GCD  = 4'd6;
    localparam logic [3:0] S_DN   = 4'd7;
    localparam logic [3:0] S_DD   = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    function automatic logic fits(input logic neg, input logic [W-1:0] mag);
        return neg ? (mag <= HALF) : (mag < HALF);
    endfunction

    function automatic logic [63:0] to64(input logic neg, input logic [W-1:0] mag);
        logic [63:0] m;
        m = 64'(mag);
        return neg ? (~m + 64'd1) : m;
    endfunction

    logic [3:0]   r_state;
    logic         r_go;
    logic [2:0]   r_op;
    logic         r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic [W-1:0] r_an_m, r_ad_m, r_bn_m, r_bd_m;
    logic         r_p_s, r_q_s, r_d_s;
    logic [W-1:0] r_p_m, r_q_m, r_d_m;
    logic         r_rn_s, r_rd_s;
    logic [W-1:0] r_rn_m, r_rd_m;
    logic [1:0]   r_status;
    logic         r_eq;
    logic         r_flags;

    logic         r_ovalid;
    logic [63:0]  r_o_num;
    logic [63:0]  r_o_den;
    logic [1:0]   r_o_status;
    logic         r_o_eq;
    logic         r_o_zero;
    logic         r_o_one;

    // operand fields, low WORD_BITS bits as signed values
    logic [W-1:0] in_an, in_ad, in_bn, in_bd;
    logic [W-1:0] an_m, ad_m, bn_m, bd_m;

    assign in_an = i_a_num[W-1:0];
    assign in_ad = i_a_den[W-1:0];
    assign in_bn = i_b_num[W-1:0];
    assign in_bd = i_b_den[W-1:0];
    assign an_m  = in_an[W-1] ? (~in_an + W'(1)) : in_an;
    assign ad_m  = in_ad[W-1] ? (~in_ad + W'(1)) : in_ad;
    assign bn_m  = in_bn[W-1] ? (~in_bn + W'(1)) : in_bn;
    assign bd_m  = in_bd[W-1] ? (~in_bd + W'(1)) : in_bd;

    logic               accept;
    logic               iter_state;
    t_iter_req          iter_req;
    logic [W-1:0]       iter_x;
    logic [W-1:0]       iter_y;
    logic               mul_s;
    logic               iter_done;
    logic [2*W-1:0]     iter_prod;
    logic [W-1:0]       iter_res;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign iter_state = (r_state == S_M1) || (r_state == S_M2) || (r_state == S_M3) ||
                        (r_state == S_GCD) || (r_state == S_DN) || (r_state == S_DD);

    always_comb begin
        iter_x = r_an_m;
        iter_y = r_bd_m;
        mul_s  = r_an_s ^ r_bd_s;
        iter_req.cmd = CMD_MUL;
        unique case (r_state)
            S_M1: begin
                iter_x = r_an_m;
                iter_y = (r_op == OP_MUL) ? r_bn_m : r_bd_m;
                mul_s  = r_an_s ^ ((r_op == OP_MUL) ? r_bn_s : r_bd_s);
            end
            S_M2: begin
                iter_x = r_bn_m;
                iter_y = r_ad_m;
                mul_s  = (r_bn_s ^ (r_op == OP_SUB)) ^ r_ad_s;
            end
            S_M3: begin
                iter_x = r_ad_m;
                iter_y = (r_op == OP_DIV) ? r_bn_m : r_bd_m;
                mul_s  = r_ad_s ^ ((r_op == OP_DIV) ? r_bn_s : r_bd_s);
            end
            S_GCD: begin
                iter_x = r_p_m;
                iter_y = r_d_m;
                iter_req.cmd = CMD_GCD;
            end
            S_DN: begin
                iter_x = r_p_m;
                iter_y = r_q_m;
                iter_req.cmd = CMD_DIV;
            end
            S_DD: begin
                iter_x = r_d_m;
                iter_y = r_q_m;
                iter_req.cmd = CMD_DIV;
            end
            default: begin
                iter_req.cmd = CMD_MUL;
            end
        endcase
        iter_req.start = iter_state && !r_go;
    end

    rau_iter #(
        .WORD_BITS(WORD_BITS)
    ) u_iter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (iter_req),
        .i_x    (iter_x),
        .i_y    (iter_y),
        .o_done (iter_done),
        .o_prod (iter_prod),
        .o_res  (iter_res)
    );

    // product fit check
    logic prod_neg;
    logic prod_ok;

    assign prod_neg = mul_s && (iter_prod != '0);
    assign prod_ok  = (iter_prod[2*W-1:W] == '0) && fits(prod_neg, iter_prod[W-1:0]);

    // signed sum of the two cross products
    logic         add_same;
    logic         add_ge;
    logic [W:0]   add_mag;
    logic         add_neg;
    logic         add_ok;

    always_comb begin
        add_same = (r_p_s == r_q_s);
        add_ge   = (r_p_m >= r_q_m);
        if (add_same) begin
            add_mag = {1'b0, r_p_m} + {1'b0, r_q_m};
        end else if (add_ge) begin
            add_mag = {1'b0, r_p_m - r_q_m};
        end else begin
            add_mag = {1'b0, r_q_m - r_p_m};
        end
        add_neg = ((add_same || add_ge) ? r_p_s : r_q_s) && (add_mag != '0);
        add_ok  = !add_mag[W] && fits(add_neg, add_mag[W-1:0]);
    end

    logic fin_neg;
    logic fin_ok;

    assign fin_neg = (r_p_s != r_d_s) && (r_rn_m != '0);
    assign fin_ok  = fits(fin_neg, r_rn_m) && (r_rd_m < HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // the done state reloads the output register itself
            if (r_ovalid && !i_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= i_operation;
                        r_an_s   <= in_an[W-1];
                        r_ad_s   <= in_ad[W-1];
                        r_bn_s   <= in_bn[W-1];
                        r_bd_s   <= in_bd[W-1];
                        r_an_m   <= an_m;
                        r_ad_m   <= ad_m;
                        r_bn_m   <= bn_m;
                        r_bd_m   <= bd_m;
                        r_flags  <= 1'b1;
                        r_eq     <= 1'b0;
                        r_status <= ST_OK;
                        r_rn_s   <= 1'b0;
                        r_rn_m   <= '0;
                        r_rd_s   <= 1'b0;
                        r_rd_m   <= '0;
                        r_go     <= 1'b0;
                        case (i_operation) inside
                            OP_ADD, OP_SUB, OP_MUL: begin
                                r_state <= S_M1;
                            end
                            OP_DIV: begin
                                if (bn_m == '0) begin
                                    r_status <= ST_ZDEN;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_M1;
                                end
                            end
                            OP_NORM: begin
                                if (ad_m == '0) begin
                                    r_rn_s   <= in_an[W-1];
                                    r_rn_m   <= an_m;
                                    r_status <= ST_ZDEN;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_p_s   <= in_an[W-1];
                                    r_p_m   <= an_m;
                                    r_d_s   <= in_ad[W-1];
                                    r_d_m   <= ad_m;
                                    r_state <= S_CHK;
                                end
                            end
                            OP_NEG: begin
                                // negating the most negative value cannot be held
                                if (in_an[W-1] && (an_m == HALF)) begin
                                    r_status <= ST_OVF;
                                end else begin
                                    r_rn_s   <= !in_an[W-1] && (an_m != '0);
                                    r_rn_m   <= an_m;
                                    r_rd_s   <= in_ad[W-1];
                                    r_rd_m   <= ad_m;
                                    r_status <= (ad_m == '0) ? ST_ZDEN : ST_OK;
                                end
                                r_state <= S_DONE;
                            end
                            OP_EQ: begin
                                r_eq    <= (in_an == in_bn) && (in_ad == in_bd);
                                r_flags <= 1'b0;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_flags <= 1'b0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_M1, S_M2, S_M3: begin
                    if (!r_go) begin
                        r_go <= 1'b1;
                    end else if (iter_done) begin
                        r_go <= 1'b0;
                        if (!prod_ok) begin
                            r_status <= ST_OVF;
                            r_state  <= S_DONE;
                        end else if (r_state == S_M1) begin
                            r_p_s   <= prod_neg;
                            r_p_m   <= iter_prod[W-1:0];
                            r_state <= ((r_op == OP_ADD) || (r_op == OP_SUB)) ? S_M2 : S_M3;
                        end else if (r_state == S_M2) begin
                            r_q_s   <= prod_neg;
                            r_q_m   <= iter_prod[W-1:0];
                            r_state <= S_ADD;
                        end else begin
                            r_d_s   <= prod_neg;
                            r_d_m   <= iter_prod[W-1:0];
                            r_state <= S_CHK;
                        end
                    end
                end
                S_ADD: begin
                    if (!add_ok) begin
                        r_status <= ST_OVF;
                        r_state  <= S_DONE;
                    end else begin
                        r_p_s   <= add_neg;
                        r_p_m   <= add_mag[W-1:0];
                        r_state <= S_M3;
                    end
                end
                S_CHK: begin
                    if (r_d_m == '0) begin
                        r_status <= ST_ZDEN;
                        r_state  <= S_DONE;
                    end else if (r_p_m == '0) begin
                        r_rd_m  <= W'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD, S_DN, S_DD: begin
                    if (!r_go) begin
                        r_go <= 1'b1;
                    end else if (iter_done) begin
                        r_go <= 1'b0;
                        if (r_state == S_GCD) begin
                            r_q_m   <= iter_res;
                            r_state <= S_DN;
                        end else if (r_state == S_DN) begin
                            r_rn_m  <= iter_res;
                            r_state <= S_DD;
                        end else begin
                            r_rd_m  <= iter_res;
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (fin_ok) begin
                        r_rn_s <= fin_neg;
                        r_rd_s <= 1'b0;
                    end else begin
                        r_rn_s   <= 1'b0;
                        r_rn_m   <= '0;
                        r_rd_s   <= 1'b0;
                        r_rd_m   <= '0;
                        r_status <= ST_OVF;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid   <= 1'b1;
                        r_o_num    <= to64(r_rn_s, r_rn_m);
                        r_o_den    <= to64(r_rd_s, r_rd_m);
                        r_o_status <= r_status;
                        r_o_eq     <= r_eq;
                        r_o_zero   <= r_flags && (r_rn_m == '0);
                        r_o_one    <= r_flags && (r_rd_m != '0) && (r_rn_s == r_rd_s) &&
                                      (r_rn_m == r_rd_m);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_result_num = r_o_num;
    assign o_result_den = r_o_den;
    assign o_status     = r_o_status;
    assign o_is_equal   = r_o_eq;
    assign o_is_zero    = r_o_zero;
    assign o_is_one     = r_o_one;

endmodule

FILE: sv/rau_checker.sv
// ---------------------------------------------------------------------------
// rau_checker
// port-level checks for the rational arithmetic unit, bound to the top level
// ---------------------------------------------------------------------------
`include "rational_arithmetic_unit_defines.svh"

module rau_checker
    import rau_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_result_num,
    input logic [63:0] o_result_den,
    input logic [1:0]  o_status,
    input logic        o_is_equal,
    input logic        o_is_zero,
    input logic        o_is_one
);

    `RAU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")
    `RAU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "not busy after a transaction was taken")
    `RAU_ASSERT_NOW(a_ovf_zero, i_clk, i_rst_n, o_valid && (o_status == ST_OVF), (o_result_num == 64'd0) && (o_result_den == 64'd0) && o_is_zero, "overflow result is not 0/0")
    `RAU_ASSERT_NOW(a_equal_clean, i_clk, i_rst_n, o_valid && o_is_equal, (o_status == ST_OK) && (o_result_num == 64'd0) && !o_is_zero && !o_is_one, "equal result carries other fields")
    `RAU_ASSERT_NOW(a_one_consistent, i_clk, i_rst_n, o_valid && o_is_one, !o_is_zero && (o_result_num == o_result_den), "is_one without matching fields")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_result_num(o_result_num),
    .o_result_den(o_result_den),
    .o_status    (o_status),
    .o_is_equal  (o_is_equal),
    .o_is_zero   (o_is_zero),
    .o_is_one    (o_is_one)
);
